/* rtl/core/ggws_pkg.sv */
// Package: constants, CORDIC angle table and register indexes for the wheel speed unit.
package ggws_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 5;

    localparam logic [19:0] START_NOW    = 20'd16000;
    localparam logic [19:0] START_BEFORE = 20'd160000;
    localparam logic [19:0] THR_SLOW     = 20'd24;
    localparam logic [19:0] THR_FAST     = 20'd128;
    localparam logic [19:0] NEAR_20      = 20'd320;
    localparam logic [19:0] NEAR_10      = 20'd160;
    localparam logic [15:0] INV_GAIN     = 16'd39797;
    localparam logic [30:0] PI_Q29       = 31'd1686629713;

    localparam logic [1:0] ST_DRIVE = 2'd0;
    localparam logic [1:0] ST_STOP  = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;
    localparam logic [1:0] ST_IDLE  = 2'd3;

    localparam logic [1:0] REG_TARGET_X = 2'd0;
    localparam logic [1:0] REG_TARGET_Y = 2'd1;
    localparam logic [1:0] REG_FAST     = 2'd2;
    localparam logic [1:0] REG_MEDIUM   = 2'd3;

    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0:  r = 32'd536870912;
                5'd1:  r = 32'd316933406;
                5'd2:  r = 32'd167458907;
                5'd3:  r = 32'd85004756;
                5'd4:  r = 32'd42667331;
                5'd5:  r = 32'd21354465;
                5'd6:  r = 32'd10679838;
                5'd7:  r = 32'd5340245;
                5'd8:  r = 32'd2670163;
                5'd9:  r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

/* rtl/core/ggws_if.sv */
// Interfaces: pose input channel and wheel speed result channel.
interface ggws_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] heading;
    logic        sector_visited;
    modport source (output valid, command, pos_x, pos_y, heading, sector_visited,
                    input ready);
    modport sink   (input valid, command, pos_x, pos_y, heading, sector_visited,
                    output ready);
endinterface

interface ggws_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] left_speed;
    logic [8:0] right_speed;
    logic [1:0] status;
    modport source (output valid, left_speed, right_speed, status, input ready);
    modport sink   (input valid, left_speed, right_speed, status, output ready);
endinterface

/* rtl/core/go_to_goal_wheel_speed_unit.sv */
// Top level: go-to-goal wheel speed controller with an iterative CORDIC core.
//
//  channel  dir  transaction
//  pose     in   command, pos_x, pos_y, heading, sector_visited
//  speed    out  left_speed, right_speed, status
//  cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// A start, idle or arrival item has its result valid the cycle after it is taken.
// A driving pose item runs through the single shared CORDIC add/shift stage, one
// iteration per cycle for CORDIC_STEPS iterations, then gain, error, two multiply
// steps and the output load; a heading-error stop skips the multiplies.
// One item is in work at a time; the next is taken once the result register is
// free or draining. rst_n clears control and state.
module go_to_goal_wheel_speed_unit
    import ggws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ggws_in_if.sink     in_ch,
    ggws_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CORD = 3'd1;
    localparam logic [2:0] S_MAG  = 3'd2;
    localparam logic [2:0] S_ERR  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_SPD  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  state_reg;
    logic signed [15:0] tx_reg, ty_reg;
    logic        fast_reg;
    logic [6:0]  med_reg;
    logic [19:0] dnow_reg, dbef_reg;
    logic        moving_reg;

    logic signed [26:0] x_reg, y_reg;
    logic [31:0] z_reg;
    logic [STEP_W-1:0] step_reg;
    logic [15:0] head_reg;
    logic        visited_reg;
    logic [19:0] dist_reg;
    logic signed [15:0] err_reg;
    logic [8:0]  base_reg;
    logic signed [56:0] t_reg;

    logic        ovalid_reg;
    logic        ovalid_next;
    logic [8:0]  oleft_reg, oright_reg;
    logic [1:0]  ostat_reg;

    logic        take_in;
    logic        stop_now;
    logic        oload;
    logic [19:0] thr;
    logic signed [26:0] sx, sy;
    logic signed [16:0] dx, dy;
    logic [43:0] magp;
    logic [20:0] mag;
    logic [15:0] zr;
    logic signed [64:0] lsum, rsum;
    logic [8:0]  lsp, rsp;

    function automatic logic [8:0] sat_speed(input logic signed [64:0] q);
        logic signed [64:0] a;
        logic [20:0] v;
        begin
            a = q[64] ? -q : q;
            v = a[64:44];
            if (q[64] || v > 21'd511) sat_speed = (q[64] && v != 21'd0) ? 9'd0
                                                 : (q[64] ? 9'd0 : 9'd511);
            else sat_speed = v[8:0];
        end
    endfunction

    assign in_ch.ready = (state_reg == S_IDLE) && !(ovalid_reg && !out_ch.ready);
    assign take_in = in_ch.valid && in_ch.ready;
    assign thr = fast_reg ? THR_FAST : THR_SLOW;
    assign stop_now = !(dnow_reg > thr && dnow_reg <= dbef_reg + thr);
    assign dx = 17'(tx_reg) - 17'(signed'(in_ch.pos_x));
    assign dy = 17'(ty_reg) - 17'(signed'(in_ch.pos_y));
    assign sx = x_reg >>> step_reg;
    assign sy = y_reg >>> step_reg;
    assign magp = 44'(x_reg[26:0]) * 44'(INV_GAIN);
    assign mag = 21'((magp + 44'd8388608) >> 24);
    assign zr = 16'((z_reg + 32'h8000) >> 16);
    assign lsum = (65'(base_reg) <<< 44) + 65'(t_reg);
    assign rsum = (65'(base_reg) <<< 44) - 65'(t_reg);
    assign lsp = sat_speed(lsum);
    assign rsp = sat_speed(rsum);

    // Load the result register on an immediate result or at the end of a pass
    assign oload = (take_in && (!in_ch.command || !moving_reg || stop_now))
                 || (state_reg == S_OUT && (!ovalid_reg || out_ch.ready));
    assign ovalid_next = oload || (ovalid_reg && !out_ch.ready);

    assign out_ch.valid = ovalid_reg;
    assign out_ch.left_speed = oleft_reg;
    assign out_ch.right_speed = oright_reg;
    assign out_ch.status = ostat_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_reg <= '0; ty_reg <= '0; fast_reg <= 1'b0; med_reg <= 7'd20;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET_X: tx_reg <= signed'(cfg_data);
                REG_TARGET_Y: ty_reg <= signed'(cfg_data);
                REG_FAST:     fast_reg <= cfg_data[0];
                REG_MEDIUM:   med_reg <= cfg_data[6:0];
            endcase
        end
    end

    // Sequencer, CORDIC iterations and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; ovalid_reg <= 1'b0; moving_reg <= 1'b0;
            dnow_reg <= START_NOW; dbef_reg <= START_BEFORE;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take_in)
                    begin
                        head_reg <= in_ch.heading;
                        visited_reg <= in_ch.sector_visited;
                        if (!in_ch.command)
                        begin
                            moving_reg <= 1'b1;
                            dnow_reg <= START_NOW; dbef_reg <= START_BEFORE;
                            oleft_reg <= '0; oright_reg <= '0; ostat_reg <= ST_IDLE;
                        end
                        else if (!moving_reg)
                        begin
                            oleft_reg <= '0; oright_reg <= '0; ostat_reg <= ST_IDLE;
                        end
                        else if (stop_now)
                        begin
                            moving_reg <= 1'b0;
                            oleft_reg <= '0; oright_reg <= '0; ostat_reg <= ST_STOP;
                        end
                        else
                        begin
                            // Fold into the right half plane
                            if (dy < 0)
                            begin
                                x_reg <= -(27'(dy) <<< 8); y_reg <= -(27'(dx) <<< 8);
                                z_reg <= 32'h80000000;
                            end
                            else
                            begin
                                x_reg <= 27'(dy) <<< 8; y_reg <= 27'(dx) <<< 8;
                                z_reg <= '0;
                            end
                            step_reg <= '0;
                            state_reg <= S_CORD;
                        end
                    end
                end
                S_CORD:
                begin
                    if (!y_reg[26])
                    begin
                        x_reg <= x_reg + sy; y_reg <= y_reg - sx;
                        z_reg <= z_reg + atan_turn(step_reg);
                    end
                    else
                    begin
                        x_reg <= x_reg - sy; y_reg <= y_reg + sx;
                        z_reg <= z_reg - atan_turn(step_reg);
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(CORDIC_STEPS - 1)) state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    dist_reg <= mag[20] ? 20'hFFFFF : mag[19:0];
                    err_reg <= signed'(zr - head_reg);
                    base_reg <= fast_reg ? 9'((10'(med_reg) * 10'd5) >> 1) : 9'(med_reg);
                    state_reg <= S_ERR;
                end
                S_ERR:
                begin
                    dbef_reg <= dnow_reg;
                    dnow_reg <= dist_reg;
                    if (err_reg > 16'sd8192 || err_reg < -16'sd8192)
                    begin
                        moving_reg <= 1'b0;
                        state_reg <= S_OUT;
                        oleft_reg <= '0; oright_reg <= '0; ostat_reg <= ST_ERR;
                    end
                    else
                    begin
                        // base * err, then times pi below
                        t_reg <= 57'(signed'({1'b0, base_reg}) * err_reg);
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    t_reg <= 57'(signed'(t_reg[25:0]) * signed'({1'b0, PI_Q29}));
                    state_reg <= S_SPD;
                end
                S_SPD:
                begin
                    ostat_reg <= ST_DRIVE;
                    if (!fast_reg && !visited_reg)
                    begin
                        oleft_reg  <= lsp >> ((dist_reg < NEAR_20 ? 1 : 0)
                                             + (dist_reg < NEAR_10 ? 1 : 0));
                        oright_reg <= rsp >> ((dist_reg < NEAR_20 ? 1 : 0)
                                             + (dist_reg < NEAR_10 ? 1 : 0));
                    end
                    else
                    begin
                        oleft_reg <= lsp; oright_reg <= rsp;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ovalid_reg || out_ch.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Stopped results carry zero speeds
    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && ostat_reg != ST_DRIVE |-> oleft_reg == '0 && oright_reg == '0)
        else $error("nonzero speed on a stop result");
    // No item is taken while the CORDIC is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ch.ready)
        else $error("input ready during work");
    // A waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !out_ch.ready |=> ovalid_reg && $stable(ostat_reg))
        else $error("result dropped");

endmodule
